@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CSVP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CSVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/csvp_pkg.sv @@
package csvp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ShortW = 16;
  localparam int unsigned LongW  = 32;
  localparam int unsigned OutW   = 3 * ShortW + LongW;

  localparam logic [ByteW-1:0] DIGIT_ZERO = 8'h30;
  localparam logic [ByteW-1:0] DIGIT_NINE = 8'h39;
  localparam logic [ByteW-1:0] COMMA_CHAR = 8'h2C;

  localparam logic [LongW+3:0] SHORT_LIMIT = 36'h0_0000_FFFF;
  localparam logic [LongW+3:0] LONG_LIMIT  = 36'h0_FFFF_FFFF;

  typedef enum logic [1:0] {
    FLD_DUTY = 2'd0,
    FLD_HIGH = 2'd1,
    FLD_LOW  = 2'd2,
    FLD_FREQ = 2'd3
  } field_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ByteW-1:0] data;
  } item_t;

  typedef struct packed {
    logic [ShortW-1:0] duty;
    logic [ShortW-1:0] high;
    logic [ShortW-1:0] low;
    logic [LongW-1:0]  freq;
    logic              valid;
  } latest_t;

endpackage

@@ src/csvp_parser.sv @@
module csvp_parser
  import csvp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output latest_t latest
);

  field_t            pos_r, pos_nxt;
  logic              seen_r, seen_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LongW-1:0]  acc_r, acc_nxt;
  logic [ShortW-1:0] pend_duty_r, pend_high_r, pend_low_r;
  latest_t           lat_r, lat_nxt;

  logic              is_digit;
  logic [3:0]        digit;
  logic [LongW+3:0]  prod;
  logic [LongW+3:0]  limit;
  logic              store_pend;

  assign is_digit = (item.data >= DIGIT_ZERO) && (item.data <= DIGIT_NINE);
  assign digit    = 4'(item.data - DIGIT_ZERO);
  assign prod     = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {{LongW{1'b0}}, digit};
  assign limit    = (pos_r == FLD_FREQ) ? LONG_LIMIT : SHORT_LIMIT;

  always_comb begin
    pos_nxt    = pos_r;
    seen_nxt   = seen_r;
    ovf_nxt    = ovf_r;
    acc_nxt    = acc_r;
    lat_nxt    = lat_r;
    store_pend = 1'b0;
    if (step && item.op == OP_BYTE) begin
      if (is_digit) begin
        seen_nxt = 1'b1;
        if (prod > limit) begin
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = prod[LongW-1:0];
        end
      end else if (seen_r && pos_r == FLD_FREQ) begin
        if (!ovf_r) begin
          lat_nxt.duty  = pend_duty_r;
          lat_nxt.high  = pend_high_r;
          lat_nxt.low   = pend_low_r;
          lat_nxt.freq  = acc_r;
          lat_nxt.valid = 1'b1;
        end
        pos_nxt  = FLD_DUTY;
        seen_nxt = 1'b0;
        ovf_nxt  = 1'b0;
        acc_nxt  = '0;
      end else if (seen_r && item.data == COMMA_CHAR) begin
        store_pend = 1'b1;
        pos_nxt    = field_t'(pos_r + 2'd1);
        seen_nxt   = 1'b0;
        acc_nxt    = '0;
      end else begin
        pos_nxt  = FLD_DUTY;
        seen_nxt = 1'b0;
        ovf_nxt  = 1'b0;
        acc_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= FLD_DUTY;
      seen_r      <= 1'b0;
      ovf_r       <= 1'b0;
      acc_r       <= '0;
      lat_r.valid <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      seen_r      <= seen_nxt;
      ovf_r       <= ovf_nxt;
      acc_r       <= acc_nxt;
      lat_r.valid <= lat_nxt.valid;
    end
    lat_r.duty <= lat_nxt.duty;
    lat_r.high <= lat_nxt.high;
    lat_r.low  <= lat_nxt.low;
    lat_r.freq <= lat_nxt.freq;
  end

  always_ff @(posedge clk) begin
    if (store_pend) begin
      unique case (pos_r)
        FLD_DUTY: pend_duty_r <= acc_r[ShortW-1:0];
        FLD_HIGH: pend_high_r <= acc_r[ShortW-1:0];
        default:  pend_low_r  <= acc_r[ShortW-1:0];
      endcase
    end
  end

  assign latest = lat_r;

endmodule

@@ src/csv_four_number_record_parser_core.sv @@
// Parses ASCII beats into records of four comma-joined decimal numbers
// (duty, high, low up to 65535; frequency up to 4294967295) and keeps the
// values of the last complete, in-range record. A beat with in_tuser low
// carries a received character; a beat with in_tuser high is a report tick
// and yields one output beat with the latest values, or nothing if no record
// has been accepted since reset. One beat is taken every cycle unless the input
// stalls. Each item is registered at the input and processed from that register,
// and a tick's result is registered in the output register. The input stalls
// only while a pending tick finds the output register still held.
module csv_four_number_record_parser_core
  import csvp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [ByteW-1:0] in_tdata,  // data_byte
  input  logic            in_tuser,   // operation
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [OutW-1:0] out_tdata   // duty_value, high_value, low_value, frequency_value
);

  logic          in_v_r;
  item_t         in_item_r;
  logic          emit;
  logic          out_free;
  logic          proceed;
  latest_t       latest;
  logic          out_v_r;
  logic [OutW-1:0] out_data_r;

  assign emit     = (in_item_r.op == OP_TICK) && latest.valid;
  assign out_free = !out_v_r || out_tready;
  assign proceed  = in_v_r && (!emit || out_free);
  assign in_tready = !in_v_r || proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.op   <= op_t'(in_tuser);
      in_item_r.data <= in_tdata;
    end
  end

  csvp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (proceed),
    .item   (in_item_r),
    .latest (latest)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= proceed && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && emit) begin
      out_data_r <= {latest.freq, latest.low, latest.high, latest.duty};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

@@ src/csvp_checker.sv @@
`include "assert_macros.svh"

module csvp_checker
  import csvp_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_tvalid,
  input logic            in_tready,
  input logic [ByteW-1:0] in_tdata,
  input logic            in_tuser,
  input logic            out_tvalid,
  input logic            out_tready,
  input logic [OutW-1:0] out_tdata
);

  logic tick_beat;
  logic out_hold;

  assign tick_beat = in_tvalid && in_tready && in_tuser;
  assign out_hold  = out_tvalid && !out_tready;

  `CSVP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_hold, out_tvalid && $stable(out_tdata))
  `CSVP_ASSERT_NOW(a_rise_from_tick, clk, rst_n, $rose(out_tvalid), $past(tick_beat, 2))
  `CSVP_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_tready, out_tvalid && ^in_tdata !== 1'bx)

endmodule

bind csv_four_number_record_parser_core csvp_checker u_csvp_checker (.*);
